/* hw/rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned CfgW   = 5;

  localparam logic [CfgW-1:0] CapReset = 5'd16;

  // Operation codes carried in the input tuser.
  localparam logic OpEnq = 1'b0;
  localparam logic OpDeq = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic [ValueW-1:0] value;
    logic [PrioW-1:0]  prio;
  } spq_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/spq_cell.sv */
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none

module spq_cell (
  input  wire logic                      clk_i,
  input  wire spq_pkg::spq_cmd_t         cmd_i,
  input  wire logic                      occ_i,
  input  wire logic                      left_lt_i,
  input  wire logic [spq_pkg::ValueW-1:0] left_value_i,
  input  wire logic [spq_pkg::PrioW-1:0]  left_prio_i,
  input  wire logic [spq_pkg::ValueW-1:0] right_value_i,
  input  wire logic [spq_pkg::PrioW-1:0]  right_prio_i,
  output logic                           lt_o,
  output logic [spq_pkg::ValueW-1:0]     value_o,
  output logic [spq_pkg::PrioW-1:0]      prio_o
);
  import spq_pkg::*;

  logic [ValueW-1:0] value_q, value_d;
  logic [PrioW-1:0]  prio_q, prio_d;

  // Entries ahead of the insertion point have a strictly smaller priority.
  assign lt_o = occ_i && (prio_q < cmd_i.prio);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (cmd_i.enq) begin
      if (!lt_o) begin
        if (left_lt_i) begin
          value_d = cmd_i.value;
          prio_d  = cmd_i.prio;
        end else begin
          value_d = left_value_i;
          prio_d  = left_prio_i;
        end
      end
    end else if (cmd_i.deq) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

`default_nettype wire

/* hw/rtl/sorted_priority_queue.sv */
// Top level of the sorted priority queue: cell chain, entry count and result register.
`default_nettype none

// Bounded priority queue of up to DEPTH entries kept sorted in a row of cells,
// head in cell 0. Input tuser[0] selects enqueue (0) or dequeue (1); the smallest
// priority leaves first, and among equal priorities the newest. Every input
// transaction yields one result transaction, registered in the cycle after acceptance; all
// cells compare against the new priority and shift in parallel, so one item is
// taken per cycle while the result register is empty or being drained. The
// capacity register (reset 16, saturating at DEPTH) may be written only while
// the queue is idle; lowering it below the fill keeps the entries held.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // capacity limit write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [spq_pkg::CfgW-1:0] cfg_data_i,
  // tdata: value_in[31:0], priority_in[47:32]; tuser: op[0]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic [0:0]  s_axis_tuser,
  // tdata: value_out[31:0], priority_out[47:32], fill_level[52:48], zeros above
  // tuser: status[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned LimW = (CntW > CfgW) ? CntW : CfgW;

  logic [CfgW-1:0] cap_q;
  logic [CntW-1:0] count_q, count_d;

  logic            out_valid_q;
  logic [55:0]     out_data_q;
  logic [1:0]      out_user_q;

  logic            accept, is_enq, full, empty;
  spq_cmd_t        cmd;

  logic [DEPTH-1:0]  occ, lt;
  logic [ValueW-1:0] cell_value [DEPTH];
  logic [PrioW-1:0]  cell_prio  [DEPTH];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_enq        = (s_axis_tuser[0] == OpEnq);
  assign full          = (LimW'(count_q) >= LimW'(cap_q)) || (count_q >= CntW'(DEPTH));
  assign empty         = (count_q == '0);

  assign cmd.enq   = accept && is_enq && !full;
  assign cmd.deq   = accept && !is_enq && !empty;
  assign cmd.value = s_axis_tdata[31:0];
  assign cmd.prio  = s_axis_tdata[47:32];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                left_lt;
    logic [ValueW-1:0]   left_value, right_value;
    logic [PrioW-1:0]    left_prio, right_prio;

    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_value = '0;
      assign left_prio  = '0;
    end else begin : g_mid
      assign left_lt    = lt[i-1];
      assign left_value = cell_value[i-1];
      assign left_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = '0;
      assign right_prio  = '0;
    end else begin : g_body
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occ_i         (occ[i]),
      .left_lt_i     (left_lt),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .lt_o          (lt[i]),
      .value_o       (cell_value[i]),
      .prio_o        (cell_prio[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.enq) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.deq) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q[31:0]  <= cmd.deq ? cell_value[0] : '0;
      out_data_q[47:32] <= cmd.deq ? cell_prio[0] : '0;
      out_data_q[52:48] <= CfgW'(count_d);
      out_data_q[55:53] <= '0;
      if (is_enq) begin
        out_user_q <= full ? ST_FULL : ST_OK;
      end else begin
        out_user_q <= empty ? ST_EMPTY : ST_OK;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_enq && !empty |=> count_q == $past(count_q) - CntW'(1))
    else $error("dequeue did not remove one entry");

  a_enq_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_enq && full |=> m_axis_tuser == ST_FULL && count_q == $past(count_q))
    else $error("refused enqueue changed the queue");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> m_axis_tdata[47:0] == '0)
    else $error("empty dequeue returned data");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the sorted priority queue: stream stimulus, shadow queue, checks.
module tb;
  import spq_pkg::*;

  localparam int QDepth = 16;

  typedef struct {
    logic [ValueW-1:0] value;
    logic [PrioW-1:0]  prio;
    logic [1:0]        status;
    logic [CfgW-1:0]   fill;
  } pq_outcome_t;

  // Shadow copy of the queue; predicts each result when a request is accepted.
  class pq_scoreboard;
    logic [ValueW-1:0] held_value [QDepth];
    logic [PrioW-1:0]  held_prio [QDepth];
    int                held_count;
    logic [CfgW-1:0]   cap_reg;
    pq_outcome_t       due_results [$];
    int unsigned       mismatches, n_results, n_enq, n_full, n_deq, n_empty, peak_fill;

    function new();
      held_count = 0;
      cap_reg    = CapReset;
      mismatches = 0;
      n_results  = 0;
      n_enq      = 0;
      n_full     = 0;
      n_deq      = 0;
      n_empty    = 0;
      peak_fill  = 0;
    endfunction

    function void set_capacity(logic [CfgW-1:0] cap);
      cap_reg = cap;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch at result %0d: %s", $time, n_results, msg);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) flag($sformatf("%s expected %h, got %h", name, want, got));
    endfunction

    // Applies one accepted request to the shadow queue and queues its outcome.
    function void note_request(logic op, logic [ValueW-1:0] val, logic [PrioW-1:0] pri);
      pq_outcome_t o;
      int lim;
      int pos;
      int i;
      o.value  = '0;
      o.prio   = '0;
      o.status = ST_OK;
      lim = (int'(cap_reg) > QDepth) ? QDepth : int'(cap_reg);
      if (op == OpEnq) begin
        if (held_count >= lim) begin
          o.status = ST_FULL;
          n_full++;
        end else begin
          // goes behind smaller priorities, ahead of equal ones
          pos = 0;
          while (pos < held_count && held_prio[pos] < pri) pos++;
          for (i = held_count; i > pos; i--) begin
            held_value[i] = held_value[i-1];
            held_prio[i]  = held_prio[i-1];
          end
          held_value[pos] = val;
          held_prio[pos]  = pri;
          held_count++;
          n_enq++;
          if (held_count > peak_fill) peak_fill = held_count;
        end
      end else begin
        if (held_count == 0) begin
          o.status = ST_EMPTY;
          n_empty++;
        end else begin
          o.value = held_value[0];
          o.prio  = held_prio[0];
          for (i = 1; i < held_count; i++) begin
            held_value[i-1] = held_value[i];
            held_prio[i-1]  = held_prio[i];
          end
          held_count--;
          n_deq++;
        end
      end
      o.fill = held_count[CfgW-1:0];
      due_results.push_back(o);
    endfunction

    function void check_result(logic [55:0] data, logic [1:0] user);
      pq_outcome_t e;
      n_results++;
      if (due_results.size() == 0) begin
        flag($sformatf("unexpected result data %h status %h", data, user));
        return;
      end
      e = due_results.pop_front();
      cmp_field("value_out", e.value, data[31:0]);
      cmp_field("priority_out", 32'(e.prio), 32'(data[47:32]));
      cmp_field("fill_level", 32'(e.fill), 32'(data[52:48]));
      cmp_field("tdata pad", 32'd0, 32'(data[55:53]));
      cmp_field("status", 32'(e.status), 32'(user));
    endfunction

    function void close_out();
      if (due_results.size() != 0)
        flag($sformatf("%0d expected results never arrived", due_results.size()));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata = '0;   // value_in[31:0], priority_in[47:32]
  logic [0:0]          s_axis_tuser = '0;   // op[0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [55:0]         m_axis_tdata;        // value_out[31:0], priority_out[47:32], fill[52:48]
  logic [1:0]          m_axis_tuser;        // status[1:0]

  int                  tx_idle_pct = 34;
  int                  rx_idle_pct = 88;
  int unsigned         n_sent = 0;
  int unsigned         n_cfg = 0;
  pq_scoreboard        sb = new();

  sorted_priority_queue #(.DEPTH(QDepth)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= (int'($urandom_range(99)) >= rx_idle_pct);
  end

  // results first: a result at this edge belongs to an earlier request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[47:32]);
    end
  end

  task automatic send_op(input logic op, input logic [ValueW-1:0] val,
                         input logic [PrioW-1:0] pri);
    if (int'($urandom_range(99)) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while (int'($urandom_range(99)) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pri, val};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CfgW-1:0] cap);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_capacity(cap);
    n_cfg++;
  endtask

  task automatic send_random(input int enq_pct);
    logic [ValueW-1:0] val;
    logic [PrioW-1:0]  pri;
    val = $urandom;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = 32'h0000_0000;
        default: val = 32'hFFFF_FFFF;
      endcase
    end
    case ($urandom_range(9))
      0, 1, 2, 3: pri = 16'($urandom_range(7));   // dense priorities give ties
      4, 5, 6, 7: pri = 16'($urandom);
      8: pri = 16'hFFFF;
      default: pri = ($urandom_range(1) != 0) ? 16'h0000 : 16'h8000;
    endcase
    send_op((int'($urandom_range(99)) < enq_pct) ? OpEnq : OpDeq, val, pri);
  endtask

  initial begin
    int seg;
    int k;
    int guard;
    logic [CfgW-1:0] cap;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ordering, ties, signed extremes, empty dequeue
    send_op(OpDeq, 32'h1234_5678, 16'h4321);
    send_op(OpEnq, 32'h7FFF_FFFF, 16'hFFFF);
    send_op(OpEnq, 32'h8000_0000, 16'h0000);
    send_op(OpEnq, 32'h0000_0000, 16'h0000);
    send_op(OpEnq, 32'hFFFF_FFFF, 16'h8000);
    send_op(OpEnq, 32'h0000_0001, 16'hFFFF);
    send_op(OpEnq, 32'h5A5A_5A5A, 16'h0001);
    repeat (7) send_op(OpDeq, 32'h0, 16'h0);
    // zero capacity refuses everything
    write_capacity(5'd0);
    send_op(OpEnq, 32'hAAAA_5555, 16'h1234);
    send_op(OpDeq, 32'hFFFF_FFFF, 16'hFFFF);
    write_capacity(5'd1);
    send_op(OpEnq, 32'h0000_0005, 16'h0005);
    send_op(OpEnq, 32'h0000_0003, 16'h0003);
    send_op(OpDeq, 32'h0, 16'h0);
    // capacity lowered below the fill keeps the entries
    write_capacity(5'd16);
    send_op(OpEnq, 32'h0000_0009, 16'h0009);
    send_op(OpEnq, 32'h0000_0008, 16'h0008);
    send_op(OpEnq, 32'h0000_0007, 16'h0007);
    write_capacity(5'd2);
    send_op(OpEnq, 32'h0000_0006, 16'h0006);
    send_op(OpDeq, 32'h0, 16'h0);
    send_op(OpDeq, 32'h0, 16'h0);
    send_op(OpEnq, 32'h0000_0004, 16'h0004);

    for (seg = 0; seg < 18; seg++) begin
      if (seg == 6) begin
        tx_idle_pct = 88;
        rx_idle_pct = 34;
      end else if (seg == 12) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (seg)
        0: cap = 5'd31;
        1: cap = 5'd1;
        2: cap = 5'd0;
        3: cap = 5'd16;
        4: cap = 5'd17;
        default: begin
          case ($urandom_range(7))
            0: cap = 5'd16;
            1: cap = 5'($urandom_range(17, 31));
            2: cap = 5'd1;
            default: cap = 5'($urandom_range(2, 15));
          endcase
        end
      endcase
      write_capacity(cap);
      // fill-heavy first half, drain-heavy second half
      k = int'($urandom_range(60, 80));
      repeat (43) send_random(k);
      k = int'($urandom_range(25, 45));
      repeat (43) send_random(k);
    end

    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    sb.close_out();

    $display("Sent %0d requests, checked %0d results over %0d capacity writes",
             n_sent, sb.n_results, n_cfg);
    $display("Stored %0d, refused full %0d, dequeued %0d, empty dequeues %0d, peak fill %0d",
             sb.n_enq, sb.n_full, sb.n_deq, sb.n_empty, sb.peak_fill);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("Some tests failed");
    $finish;
  end
endmodule

/* sorted_priority_queue.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/tb.sv
